// ===== rtl/apwm_pkg.sv =====
// Shared types and constants for the approximate pattern window matcher.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package apwm_pkg;

	// Pattern storage is fixed by the three 64-bit character registers.
	localparam int PAT_CHARS = 24;
	localparam int CODE_W    = 52;
	localparam int CLEN_W    = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 64;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_BUDGET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INDEL_BUDGET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_MID = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 3'd5;

	// Alignment step codes.
	localparam logic [1:0] STEP_MATCH  = 2'd0;
	localparam logic [1:0] STEP_INSERT = 2'd1;
	localparam logic [1:0] STEP_DELETE = 2'd2;
	localparam logic [1:0] STEP_SUBST  = 2'd3;

	typedef struct packed {
		logic [7:0] text_char;
		logic       last_char;
	} text_word_t;

	typedef struct packed {
		logic [31:0]       window_start_index;
		logic [1:0]        mismatches_used;
		logic [1:0]        indels_used;
		logic [2:0]        edit_distance;
		logic [CODE_W-1:0] alignment_code;
		logic [CLEN_W-1:0] code_length;
	} match_word_t;

	// Status from the search sequencer to the top level.
	typedef struct packed {
		logic busy;
		logic done;
		logic hit;
	} srch_stat_t;

	// Alignment found by the search sequencer.
	typedef struct packed {
		logic [1:0]        mm_used;
		logic [1:0]        id_used;
		logic [2:0]        edit_dist;
		logic [CODE_W-1:0] code;
		logic [CLEN_W-1:0] clen;
	} srch_res_t;

endpackage

`default_nettype wire

// ===== rtl/apwm_window.sv =====
// Text window shift register with fill count and saturating start index.
// Depends on apwm_pkg for the input word type.
`timescale 1ns / 1ps
`default_nettype none

module apwm_window #(
	parameter int MAX_PATTERN = 23
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              accept,
	input  apwm_pkg::text_word_t             word,
	input  wire [$clog2(MAX_PATTERN+1)-1:0]  len,
	output logic                             start,
	output logic [31:0]                      position,
	output logic [MAX_PATTERN*8-1:0]         window
);

	localparam int LW = $clog2(MAX_PATTERN + 1);

	logic [MAX_PATTERN*8-1:0] store_q;
	logic [LW-1:0]            fill_q;
	logic [LW-1:0]            fill_n;
	logic [31:0]              pos_q;

	// Fill count after this word, saturating at the window depth.
	assign fill_n   = (fill_q == LW'(MAX_PATTERN)) ? fill_q : fill_q + LW'(1);
	assign start    = accept && (fill_n >= len);
	assign position = pos_q;
	assign window   = store_q;

	// Newest byte enters at the top of the store.
	always_ff @(posedge clk) begin
		if (accept) begin
			store_q <= (MAX_PATTERN*8)'({word.text_char, store_q} >> 8);
		end
	end

	// Fill count and window start index; both restart after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q  <= '0;
		end else if (accept) begin
			if (word.last_char) begin
				fill_q <= '0;
				pos_q  <= '0;
			end else begin
				fill_q <= fill_n;
				if (start && (pos_q != 32'hFFFF_FFFF)) begin
					pos_q <= pos_q + 32'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/apwm_search.sv =====
// Depth-first backtracking search sequencer with a shift-register move stack.
// Depends on apwm_pkg for step codes and the status and result types.
`timescale 1ns / 1ps
`default_nettype none

module apwm_search #(
	parameter int MAX_PATTERN = 23
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire [$clog2(MAX_PATTERN+1)-1:0]  len,
	input  wire [1:0]                        mm_budget,
	input  wire [1:0]                        id_budget,
	input  wire [apwm_pkg::PAT_CHARS*8-1:0]  pattern,
	input  wire [MAX_PATTERN*8-1:0]          window,
	input  wire                              take,
	output apwm_pkg::srch_stat_t             stat,
	output apwm_pkg::srch_res_t              res
);

	localparam int LW    = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int DW    = $clog2(MAX_PATTERN + 4);
	localparam int SW    = 2 * (MAX_PATTERN + 3);

	typedef enum logic [1:0] {S_IDLE, S_EXPAND, S_BACK, S_DONE} state_t;

	state_t         state_q;
	logic [LW-1:0]  pl_q, tl_q;
	logic [1:0]     mm_q, id_q;
	logic [DW-1:0]  depth_q;
	logic [SW-1:0]  stack_q;
	logic [IDX_W-1:0] base_q;
	logic           hit_q;

	logic [IDX_W:0] widx;
	logic [4:0]     pidx;
	logic [7:0]     pat_b, win_b;
	logic           terminal;
	logic [1:0]     top;
	logic [LW-1:0]  ppl, ptl;
	logic [1:0]     pmm, pid;
	logic [SW+apwm_pkg::CODE_W-1:0] code_ext;
	logic [DW+apwm_pkg::CLEN_W-1:0] clen_ext;
	logic [1:0]     mu, iu;

	// Character pair under comparison at the current node.
	assign widx     = {1'b0, base_q} + (IDX_W+1)'(tl_q) - (IDX_W+1)'(1);
	assign pidx     = 5'(pl_q - LW'(1));
	assign pat_b    = pattern[pidx*8 +: 8];
	assign win_b    = window[widx[IDX_W-1:0]*8 +: 8];
	assign terminal = (pl_q == '0) || (tl_q == '0);

	// Parent node recovered by undoing the move on top of the stack.
	assign top = stack_q[1:0];
	always_comb begin
		ppl = pl_q;
		ptl = tl_q;
		pmm = mm_q;
		pid = id_q;
		case (top)
			apwm_pkg::STEP_MATCH: begin
				ppl = pl_q + LW'(1);
				ptl = tl_q + LW'(1);
			end
			apwm_pkg::STEP_INSERT: begin
				ppl = pl_q + LW'(1);
				pid = id_q + 2'd1;
			end
			apwm_pkg::STEP_DELETE: begin
				ptl = tl_q + LW'(1);
				pid = id_q + 2'd1;
			end
			default: begin
				ppl = pl_q + LW'(1);
				ptl = tl_q + LW'(1);
				pmm = mm_q + 2'd1;
			end
		endcase
	end

	// Sequencer: one node expansion or one backtrack step per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			depth_q <= '0;
			hit_q   <= 1'b0;
			pl_q    <= '0;
			tl_q    <= '0;
			mm_q    <= '0;
			id_q    <= '0;
			stack_q <= '0;
			base_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXPAND;
						pl_q    <= len;
						tl_q    <= len;
						mm_q    <= mm_budget;
						id_q    <= id_budget;
						depth_q <= '0;
						stack_q <= '0;
						base_q  <= IDX_W'(MAX_PATTERN - int'(len));
					end
				end
				S_EXPAND: begin
					if (terminal) begin
						hit_q   <= 1'b1;
						state_q <= S_DONE;
					end else if (pat_b == win_b) begin
						stack_q <= {stack_q[SW-3:0], apwm_pkg::STEP_MATCH};
						depth_q <= depth_q + DW'(1);
						pl_q    <= pl_q - LW'(1);
						tl_q    <= tl_q - LW'(1);
					end else if (id_q != 2'd0) begin
						stack_q <= {stack_q[SW-3:0], apwm_pkg::STEP_INSERT};
						depth_q <= depth_q + DW'(1);
						pl_q    <= pl_q - LW'(1);
						id_q    <= id_q - 2'd1;
					end else if (mm_q != 2'd0) begin
						stack_q <= {stack_q[SW-3:0], apwm_pkg::STEP_SUBST};
						depth_q <= depth_q + DW'(1);
						pl_q    <= pl_q - LW'(1);
						tl_q    <= tl_q - LW'(1);
						mm_q    <= mm_q - 2'd1;
					end else begin
						state_q <= S_BACK;
					end
				end
				S_BACK: begin
					if (depth_q == '0) begin
						hit_q   <= 1'b0;
						state_q <= S_DONE;
					end else if (top == apwm_pkg::STEP_INSERT) begin
						// Insertion failed, so try deletion at the same node.
						stack_q[1:0] <= apwm_pkg::STEP_DELETE;
						pl_q    <= ppl;
						tl_q    <= ptl - LW'(1);
						mm_q    <= pmm;
						id_q    <= pid - 2'd1;
						state_q <= S_EXPAND;
					end else if ((top == apwm_pkg::STEP_DELETE) && (pmm != 2'd0)) begin
						// Deletion failed, so try substitution at the same node.
						stack_q[1:0] <= apwm_pkg::STEP_SUBST;
						pl_q    <= ppl - LW'(1);
						tl_q    <= ptl - LW'(1);
						mm_q    <= pmm - 2'd1;
						id_q    <= pid;
						state_q <= S_EXPAND;
					end else begin
						// No alternative left: pop the move and keep unwinding.
						stack_q <= {2'b00, stack_q[SW-1:2]};
						depth_q <= depth_q - DW'(1);
						pl_q    <= ppl;
						tl_q    <= ptl;
						mm_q    <= pmm;
						id_q    <= pid;
					end
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The stack already holds the deepest step in its lowest bits.
	assign code_ext = {{apwm_pkg::CODE_W{1'b0}}, stack_q};
	assign clen_ext = {{apwm_pkg::CLEN_W{1'b0}}, depth_q};
	assign mu       = mm_budget - mm_q;
	assign iu       = id_budget - id_q;

	assign stat.busy = (state_q != S_IDLE);
	assign stat.done = (state_q == S_DONE);
	assign stat.hit  = hit_q;

	assign res.mm_used   = mu;
	assign res.id_used   = iu;
	assign res.edit_dist = {1'b0, mu} + {1'b0, iu};
	assign res.code      = code_ext[apwm_pkg::CODE_W-1:0];
	assign res.clen      = clen_ext[apwm_pkg::CLEN_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/approx_pattern_window_matcher_core.sv =====
// Top level of the approximate pattern window matcher: configuration
// registers, text window, search sequencer and output register.
// Depends on apwm_pkg, apwm_window and apwm_search.
//
// Usage: text bytes arrive one word at a time on text_valid/text_stall.
// Once pattern_length bytes have been seen, every byte starts a backtracking
// search of the pattern against the window; a successful alignment leaves one
// word on match_valid/match_stall. A word with last_char set ends the text and
// restarts the window and the start index.
// A byte that does not complete a window is taken while the sequencer is idle.
// A byte that starts a search is followed by the node expansions and backtrack
// steps and the release of the result, so the next byte is taken only after
// that search ends, the longest wait coming when heavy backtracking with
// budgets of three explores every node. The single search sequencer sets
// this pace, and text_stall stays high while it runs. A found result waits
// in the output register while match_stall is high, and the sequencer holds
// its next result until the register frees. Reset clears the window fill,
// the start index and both handshakes; the registers return to length 23,
// budgets of one and an all-zero pattern.
`timescale 1ns / 1ps
`default_nettype none

module approx_pattern_window_matcher_core #(
	parameter int MAX_PATTERN = 23
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                text_valid,
	output logic                               text_stall,
	input  apwm_pkg::text_word_t               text_word,
	output logic                               match_valid,
	input  wire                                match_stall,
	output apwm_pkg::match_word_t              match_word,
	input  wire                                cfg_we,
	input  wire [apwm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [apwm_pkg::CFG_W-1:0]          cfg_data
);

	localparam int LW = $clog2(MAX_PATTERN + 1);

	logic [4:0]                        len_cfg_q;
	logic [1:0]                        mm_budget_q;
	logic [1:0]                        id_budget_q;
	logic [apwm_pkg::PAT_CHARS*8-1:0]  pattern_q;
	logic [LW-1:0]                     len;
	logic                              accept;
	logic                              start;
	logic [31:0]                       position;
	logic [31:0]                       pos_q;
	logic [MAX_PATTERN*8-1:0]          window;
	logic                              take;
	logic                              load;
	logic                              match_valid_q;
	apwm_pkg::match_word_t             match_word_q;
	apwm_pkg::srch_stat_t              stat;
	apwm_pkg::srch_res_t               res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q   <= 5'd23;
			mm_budget_q <= 2'd1;
			id_budget_q <= 2'd1;
			pattern_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				apwm_pkg::CFG_PATTERN_LENGTH:  len_cfg_q <= cfg_data[4:0];
				apwm_pkg::CFG_MISMATCH_BUDGET: mm_budget_q <= cfg_data[1:0];
				apwm_pkg::CFG_INDEL_BUDGET:    id_budget_q <= cfg_data[1:0];
				apwm_pkg::CFG_PAT_LOW:         pattern_q[63:0] <= cfg_data;
				apwm_pkg::CFG_PAT_MID:         pattern_q[127:64] <= cfg_data;
				apwm_pkg::CFG_PAT_HIGH:        pattern_q[191:128] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective length: zero acts as one, and lengths beyond the store clamp.
	always_comb begin
		if (len_cfg_q == 5'd0) begin
			len = LW'(1);
		end else if (32'(len_cfg_q) > 32'(MAX_PATTERN)) begin
			len = LW'(MAX_PATTERN);
		end else begin
			len = LW'(len_cfg_q);
		end
	end

	assign accept     = text_valid && !text_stall;
	assign text_stall = stat.busy;

	apwm_window #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.word     (text_word),
		.len      (len),
		.start    (start),
		.position (position),
		.window   (window)
	);

	// Start index of the window under search.
	always_ff @(posedge clk) begin
		if (start) begin
			pos_q <= position;
		end
	end

	apwm_search #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.len       (len),
		.mm_budget (mm_budget_q),
		.id_budget (id_budget_q),
		.pattern   (pattern_q),
		.window    (window),
		.take      (take),
		.stat      (stat),
		.res       (res)
	);

	// A finished search is released once its word, if any, has a place.
	assign take = stat.done && (!stat.hit || !match_valid_q || !match_stall);
	assign load = take && stat.hit;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_valid_q <= 1'b0;
		end else if (load) begin
			match_valid_q <= 1'b1;
		end else if (!match_stall) begin
			match_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			match_word_q.window_start_index <= pos_q;
			match_word_q.mismatches_used    <= res.mm_used;
			match_word_q.indels_used        <= res.id_used;
			match_word_q.edit_distance      <= res.edit_dist;
			match_word_q.alignment_code     <= res.code;
			match_word_q.code_length        <= res.clen;
		end
	end

	assign match_valid = match_valid_q;
	assign match_word  = match_word_q;

`ifndef SYNTHESIS
	// No text word may be taken while a search is running.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> !accept)
		else $error("text word accepted during a search");

	// A result is only loaded when the output register is free or draining.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(match_valid_q && match_stall) |-> !load)
		else $error("pending result overwritten");

	// The reported distance is the sum of both counts.
	a_dist_sum: assert property (@(posedge clk) disable iff (!arst_n)
		match_valid |-> (match_word.edit_distance ==
			{1'b0, match_word.mismatches_used} + {1'b0, match_word.indels_used}))
		else $error("edit distance does not match counts");
`endif

endmodule

`default_nettype wire
